FILE: sv/isearch_pkg.sv
// Shared constants and types for the interpolation search table.
package isearch_pkg;

  localparam int unsigned TableDepth = 1024;
  localparam int unsigned IdxW       = 10;   // table index width
  localparam int unsigned CntW       = 11;   // entry_count width
  localparam int unsigned ValW       = 32;   // entry / key width
  localparam int unsigned PosW       = 12;   // signed search bound width
  localparam int unsigned QuoW       = IdxW; // probe offset width
  localparam int unsigned ProdW      = ValW + IdxW;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_LOW,
    ST_RD_HIGH,
    ST_CHECK,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_PROBE_RD,
    ST_PROBE_CMP,
    ST_FINISH
  } state_e;

endpackage

FILE: sv/isearch_div.sv
// Iterative restoring divider, one quotient bit per cycle, quotient below 2**QuoW.
module isearch_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [isearch_pkg::ProdW-1:0]     dividend_i,
  input  logic [isearch_pkg::ValW-1:0]      divisor_i,
  output logic                              done_o,
  output logic [isearch_pkg::QuoW-1:0]      quotient_o
);

  localparam int unsigned CntBits = $clog2(isearch_pkg::QuoW + 1);

  logic [isearch_pkg::ValW-1:0] rem_q, rem_d;
  logic [isearch_pkg::QuoW-1:0] sh_q, sh_d;
  logic [isearch_pkg::ValW-1:0] dvs_q, dvs_d;
  logic [CntBits-1:0]           cnt_q, cnt_d;
  logic                         busy_q, busy_d;
  logic                         done_q, done_d;
  logic [isearch_pkg::ValW:0]   trial_w;
  logic [isearch_pkg::ValW:0]   diff_w;
  logic                         ge_w;

  assign trial_w = {rem_q, sh_q[isearch_pkg::QuoW-1]};
  assign ge_w    = (trial_w >= {1'b0, dvs_q});
  assign diff_w  = trial_w - {1'b0, dvs_q};

  always_comb begin
    rem_d  = rem_q;
    sh_d   = sh_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      // dividend < divisor * 2**QuoW, so the top part is already below the divisor
      rem_d  = dividend_i[isearch_pkg::ProdW-1:isearch_pkg::QuoW];
      sh_d   = dividend_i[isearch_pkg::QuoW-1:0];
      dvs_d  = divisor_i;
      cnt_d  = CntBits'(isearch_pkg::QuoW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge_w ? diff_w[isearch_pkg::ValW-1:0] : trial_w[isearch_pkg::ValW-1:0];
      sh_d  = {sh_q[isearch_pkg::QuoW-2:0], ge_w};
      cnt_d = cnt_q - CntBits'(1);
      if (cnt_q == CntBits'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    sh_q  <= sh_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = sh_q;

endmodule

FILE: sv/interpolation_search_table_core.sv
// Top level of the interpolation search table: table memory, search sequencer, ports.
//
// Channels (valid/ready, a transfer happens when both are high at a rising edge):
//   in   : opcode_i, entry_index_i, data_value_i. A write stores data_value_i at
//          entry_index_i and gives no result. A search looks for data_value_i among
//          the first entry_count entries, which are taken to be ascending.
//   out  : found_o, found_index_o, one transfer per search.
//   cfg  : cfg_data_i sets entry_count (values above 1024 act as 1024). Write it
//          only while the block is idle; cfg_ready_o is always high.
// A write is stored at its transfer and the sequencer stays idle. A search probe runs
// the end-value reads, check and multiply, divider start, the divide and taking the
// quotient, then probe read and compare; equal end values skip the divider. A search
// not ended by a probe hit closes with end checks (RD_LOW, or RD_LOW, RD_HIGH and
// CHECK), and ST_FINISH then loads the output register.
// in_ready_o is high only while the sequencer is idle, so items are handled
// one at a time. The finished result sits in an output register; a new item is
// taken while it waits, and a later search holds its answer until the receiver
// takes the earlier one.
// Reset clears entry_count to 0 and empties the output register. Table contents
// are not cleared; searches must only touch written entries.
module interpolation_search_table_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              opcode_i,
  input  logic [isearch_pkg::IdxW-1:0]      entry_index_i,
  input  logic signed [isearch_pkg::ValW-1:0] data_value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              found_o,
  output logic [isearch_pkg::IdxW-1:0]      found_index_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [isearch_pkg::CntW-1:0]      cfg_data_i
);

  localparam int unsigned IdxW  = isearch_pkg::IdxW;
  localparam int unsigned ValW  = isearch_pkg::ValW;
  localparam int unsigned PosW  = isearch_pkg::PosW;
  localparam int unsigned CntW  = isearch_pkg::CntW;
  localparam int unsigned QuoW  = isearch_pkg::QuoW;
  localparam int unsigned ProdW = isearch_pkg::ProdW;

  // table memory, one write and one registered read port
  logic signed [ValW-1:0] mem_q [isearch_pkg::TableDepth];
  logic signed [ValW-1:0] rd_data_q;
  logic [IdxW-1:0]        rd_addr_w;
  logic                   wr_en_w;

  isearch_pkg::state_e state_q, state_d;

  logic [CntW-1:0]        count_q;
  logic signed [PosW-1:0] low_q, low_d;
  logic signed [PosW-1:0] high_q, high_d;
  logic signed [PosW-1:0] pos_q, pos_d;
  logic signed [ValW-1:0] key_q, key_d;
  logic signed [ValW-1:0] tlow_q, tlow_d;
  logic [ValW-1:0]        span_q, span_d;
  logic [ProdW-1:0]       prod_q, prod_d;
  logic                   res_found_q, res_found_d;
  logic [IdxW-1:0]        res_idx_q, res_idx_d;
  logic                   out_valid_q, out_valid_d;
  logic                   out_found_q, out_found_d;
  logic [IdxW-1:0]        out_idx_q, out_idx_d;

  logic                   in_xfer_w;
  logic [CntW-1:0]        n_w;
  logic signed [PosW-1:0] hl_w;
  logic [ValW:0]          diff_w;
  logic [ValW:0]          span_w;
  logic [ProdW-1:0]       mul_w;
  logic                   div_start_w;
  logic                   div_done_w;
  logic [QuoW-1:0]        div_q_w;
  logic [QuoW-1:0]        off_w;

  assign in_ready_o  = (state_q == isearch_pkg::ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_xfer_w   = in_valid_i && in_ready_o;
  assign wr_en_w     = in_xfer_w && (opcode_i == isearch_pkg::OP_WRITE);

  assign n_w = (count_q > CntW'(isearch_pkg::TableDepth)) ?
               CntW'(isearch_pkg::TableDepth) : count_q;

  // width of the live range, positive whenever low < high
  assign hl_w   = high_q - low_q;
  // key - t[low] and t[high] - t[low] in one extra bit
  assign diff_w = {key_q[ValW-1], key_q} - {tlow_q[ValW-1], tlow_q};
  assign span_w = {rd_data_q[ValW-1], rd_data_q} - {tlow_q[ValW-1], tlow_q};
  assign mul_w  = diff_w[ValW-1:0] * hl_w[QuoW-1:0];
  assign off_w  = (div_q_w > hl_w[QuoW-1:0]) ? hl_w[QuoW-1:0] : div_q_w;

  isearch_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_w),
    .dividend_i (prod_q),
    .divisor_i  (span_q),
    .done_o     (div_done_w),
    .quotient_o (div_q_w)
  );

  always_comb begin
    state_d     = state_q;
    low_d       = low_q;
    high_d      = high_q;
    pos_d       = pos_q;
    key_d       = key_q;
    tlow_d      = tlow_q;
    span_d      = span_q;
    prod_d      = prod_q;
    res_found_d = res_found_q;
    res_idx_d   = res_idx_q;
    out_found_d = out_found_q;
    out_idx_d   = out_idx_q;
    out_valid_d = out_valid_q && !out_ready_i;
    div_start_w = 1'b0;
    rd_addr_w   = low_q[IdxW-1:0];

    case (state_q)
      isearch_pkg::ST_IDLE: begin
        if (in_xfer_w && (opcode_i == isearch_pkg::OP_SEARCH)) begin
          key_d       = data_value_i;
          low_d       = '0;
          high_d      = $signed({1'b0, n_w}) - PosW'(1);
          res_found_d = 1'b0;
          res_idx_d   = '0;
          state_d     = isearch_pkg::ST_RD_LOW;
        end
      end
      isearch_pkg::ST_RD_LOW: begin
        rd_addr_w = low_q[IdxW-1:0];
        if (low_q > high_q) begin
          state_d = isearch_pkg::ST_FINISH;
        end else begin
          state_d = isearch_pkg::ST_RD_HIGH;
        end
      end
      isearch_pkg::ST_RD_HIGH: begin
        rd_addr_w = high_q[IdxW-1:0];
        tlow_d    = rd_data_q;
        state_d   = isearch_pkg::ST_CHECK;
      end
      isearch_pkg::ST_CHECK: begin
        // rd_data_q holds t[high] here
        if (key_q < tlow_q || key_q > rd_data_q) begin
          state_d = isearch_pkg::ST_FINISH;
        end else if (low_q == high_q) begin
          if (tlow_q == key_q) begin
            res_found_d = 1'b1;
            res_idx_d   = low_q[IdxW-1:0];
          end
          state_d = isearch_pkg::ST_FINISH;
        end else if (span_w[ValW] || span_w == '0) begin
          // equal (or descending) end values: probe at low
          pos_d   = low_q;
          state_d = isearch_pkg::ST_PROBE_RD;
        end else begin
          span_d  = span_w[ValW-1:0];
          prod_d  = mul_w;
          state_d = isearch_pkg::ST_DIV_GO;
        end
      end
      isearch_pkg::ST_DIV_GO: begin
        div_start_w = 1'b1;
        state_d     = isearch_pkg::ST_DIV_WAIT;
      end
      isearch_pkg::ST_DIV_WAIT: begin
        if (div_done_w) begin
          pos_d   = low_q + $signed({{(PosW-QuoW){1'b0}}, off_w});
          state_d = isearch_pkg::ST_PROBE_RD;
        end
      end
      isearch_pkg::ST_PROBE_RD: begin
        rd_addr_w = pos_q[IdxW-1:0];
        state_d   = isearch_pkg::ST_PROBE_CMP;
      end
      isearch_pkg::ST_PROBE_CMP: begin
        if (rd_data_q == key_q) begin
          res_found_d = 1'b1;
          res_idx_d   = pos_q[IdxW-1:0];
          state_d     = isearch_pkg::ST_FINISH;
        end else if (rd_data_q < key_q) begin
          low_d   = pos_q + PosW'(1);
          state_d = isearch_pkg::ST_RD_LOW;
        end else begin
          high_d  = pos_q - PosW'(1);
          state_d = isearch_pkg::ST_RD_LOW;
        end
      end
      isearch_pkg::ST_FINISH: begin
        // wait for the output register to free up
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_found_d = res_found_q;
          out_idx_d   = res_idx_q;
          state_d     = isearch_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = isearch_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= isearch_pkg::ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        count_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    low_q       <= low_d;
    high_q      <= high_d;
    pos_q       <= pos_d;
    key_q       <= key_d;
    tlow_q      <= tlow_d;
    span_q      <= span_d;
    prod_q      <= prod_d;
    res_found_q <= res_found_d;
    res_idx_q   <= res_idx_d;
    out_found_q <= out_found_d;
    out_idx_q   <= out_idx_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_w) begin
      mem_q[entry_index_i] <= data_value_i;
    end
    rd_data_q <= mem_q[rd_addr_w];
  end

  assign out_valid_o   = out_valid_q;
  assign found_o       = out_found_q;
  assign found_index_o = out_idx_q;

endmodule
